// File: rtl/mf3_pkg.sv
// Shared types and constants of the 3x3 median filter.
`default_nettype none

package mf3_pkg;

   localparam int PIX_W          = 8;
   localparam int CFG_W          = 10;
   localparam int CSR_IDX_W      = 2;
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;
   localparam int SIZE_RESET     = 512;
   localparam int QUEUE_DEPTH    = 4;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } req_op_type;

   typedef struct packed {
      req_op_type       op;
      logic [PIX_W-1:0] pixel_in;
   } req_beat_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_last;
   } rsp_beat_type;

   // One push into the line stores / window, as queued from front to back.
   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic [CFG_W-1:0] col;
      logic             emit;
      logic             border;
      logic             last;
   } push_op_type;

endpackage

`default_nettype wire

// File: rtl/mf3_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
`default_nettype none

interface mf3_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/mf3_front.sv
// Front end: size CSRs, frame counters and classification of request beats.
`default_nettype none

module mf3_front #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   mf3_stream_if.sink                         req_bus,
   input  wire logic                          csr_write_en,
   input  wire logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mf3_pkg::CFG_W-1:0]     csr_write_data,
   input  wire logic                          queue_full,
   output logic                               queue_push,
   output mf3_pkg::push_op_type               queue_data
);

   localparam int CW = mf3_pkg::CFG_W;
   localparam logic [CW-1:0] W_RST = CW'((mf3_pkg::SIZE_RESET > MAX_WIDTH) ?
                                         MAX_WIDTH : mf3_pkg::SIZE_RESET);
   localparam logic [CW-1:0] H_RST = CW'((mf3_pkg::SIZE_RESET > MAX_HEIGHT) ?
                                         MAX_HEIGHT : mf3_pkg::SIZE_RESET);

   function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] v, input int max_v);
      logic [CW-1:0] r;
      if (v == '0)
         r = CW'(1);
      else if (int'(v) > max_v)
         r = CW'(max_v);
      else
         r = v;
      return r;
   endfunction

   logic [CW-1:0] width_ff,   width_in;
   logic [CW-1:0] height_ff,  height_in;
   logic [CW-1:0] in_col_ff,  in_col_in;
   logic [CW-1:0] in_row_ff,  in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [CW-1:0] out_row_ff, out_row_in;
   logic [CW:0]   lead_ff,    lead_in;     // pushes so far, saturates at W+1
   logic          in_done_ff, in_done_in;  // all pixels of the frame taken
   logic          second_ff,  second_in;   // second dummy push of a drain owed

   logic [CW-1:0] w_last, h_last;
   logic          primed, accept, gen, is_pixel, emit;
   logic          col_wrap, out_wrap, out_last, border, restart;

   assign w_last   = width_ff - CW'(1);
   assign h_last   = height_ff - CW'(1);
   assign primed   = (lead_ff == ({1'b0, width_ff} + (CW+1)'(1)));
   assign col_wrap = (in_col_ff == w_last);
   assign out_wrap = (out_col_ff == w_last);
   assign out_last = out_wrap && (out_row_ff == h_last);
   assign border   = (out_row_ff == '0) || (out_row_ff == h_last) ||
                     (out_col_ff == '0) || out_wrap;

   assign req_bus.ready = !queue_full && !second_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      gen        = 1'b0;
      is_pixel   = 1'b0;
      second_in  = second_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lead_in    = lead_ff;
      in_done_in = in_done_ff;
      restart    = 1'b0;

      if (second_ff) begin
         if (!queue_full) begin
            gen       = 1'b1;
            second_in = 1'b0;
         end
      end else if (accept) begin
         case (req_bus.data.op)
            mf3_pkg::OP_PIXEL: begin
               gen      = !in_done_ff;
               is_pixel = !in_done_ff;
            end
            mf3_pkg::OP_DRAIN: begin
               if (in_done_ff) begin
                  gen       = 1'b1;
                  second_in = !primed;  // single-row frame: first drain pushes twice
               end
            end
            default: ;
         endcase
      end

      emit = gen && primed;

      if (gen) begin
         in_col_in = col_wrap ? '0 : in_col_ff + CW'(1);
         if (!primed)
            lead_in = lead_ff + (CW+1)'(1);
         if (is_pixel && col_wrap) begin
            if (in_row_ff == h_last)
               in_done_in = 1'b1;
            else
               in_row_in = in_row_ff + CW'(1);
         end
      end

      if (emit) begin
         out_col_in = out_wrap ? '0 : out_col_ff + CW'(1);
         if (out_wrap)
            out_row_in = out_row_ff + CW'(1);
         if (out_last)
            restart = 1'b1;
      end

      if (csr_write_en) begin
         case (csr_index)
            mf3_pkg::CSR_IMAGE_WIDTH: begin
               width_in  = clamp_size(csr_write_data, MAX_WIDTH);
               restart   = 1'b1;
               second_in = 1'b0;
            end
            mf3_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = clamp_size(csr_write_data, MAX_HEIGHT);
               restart   = 1'b1;
               second_in = 1'b0;
            end
            default: ;
         endcase
      end

      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lead_in    = '0;
         in_done_in = 1'b0;
      end
   end

   always_comb begin
      queue_push        = gen;
      queue_data.value  = is_pixel ? req_bus.data.pixel_in : '0;
      queue_data.col    = in_col_ff;
      queue_data.emit   = emit;
      queue_data.border = border;
      queue_data.last   = out_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= W_RST;
         height_ff  <= H_RST;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lead_ff    <= '0;
         in_done_ff <= 1'b0;
         second_ff  <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lead_ff    <= lead_in;
         in_done_ff <= in_done_in;
         second_ff  <= second_in;
      end
   end

   // A double drain push only happens once the frame's pixels are all in.
   a_second_after_frame: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> in_done_ff)
      else $error("second drain push outside drain phase");

   // The last output of a frame restarts all counters.
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (emit && out_last && !csr_write_en) |=>
         (in_col_ff == '0 && out_col_ff == '0 && out_row_ff == '0 && !in_done_ff))
      else $error("counters not restarted after last output");

endmodule

`default_nettype wire

// File: rtl/mf3_fifo.sv
// Small queue of push operations between front and back end.
`default_nettype none

module mf3_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire mf3_pkg::push_op_type push_data,
   output logic                      full,
   input  wire logic                 pop,
   output mf3_pkg::push_op_type      head,
   output logic                      not_empty
);

   localparam int DEPTH = mf3_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   mf3_pkg::push_op_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff,  count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + (PTR_W+1)'(1);
      else if (!do_push && do_pop)
         count_in = count_ff - (PTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The front end must never push into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

endmodule

`default_nettype wire

// File: rtl/mf3_back.sv
// Back end: line store memory, 3x3 window, median network and result register.
`default_nettype none

module mf3_back #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 queue_valid,
   input  wire mf3_pkg::push_op_type queue_head,
   output logic                      queue_pop,
   mf3_stream_if.source              rsp_bus
);

   localparam int PW     = mf3_pkg::PIX_W;
   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   typedef logic [2:0][2:0][PW-1:0] win_type;   // [row][col]
   typedef logic [2:0][PW-1:0]      tri_type;

   function automatic logic [PW-1:0] min2(input logic [PW-1:0] a, input logic [PW-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PW-1:0] max2(input logic [PW-1:0] a, input logic [PW-1:0] b);
      return (a < b) ? b : a;
   endfunction

   function automatic logic [PW-1:0] med3(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                          input logic [PW-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // line store entry: {older, newer}
   logic [2*PW-1:0] line_mem [MAX_WIDTH];
   logic [2*PW-1:0] rdata_ff;

   logic                 b_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   mf3_pkg::push_op_type b_op_ff;
   logic                 fwd_ff, fwd_in;
   logic [2*PW-1:0]      fwd_pair_ff;
   win_type              win_ff, win_in, s1_win_ff;
   logic                 s1_border_ff, s1_last_ff;
   tri_type              s2_lo_ff, s2_mid_ff, s2_hi_ff;
   logic [PW-1:0]        s2_center_ff, s3_center_ff;
   logic                 s2_border_ff, s2_last_ff, s3_border_ff, s3_last_ff;
   logic [PW-1:0]        s3_maxlo_ff, s3_medmid_ff, s3_minhi_ff;
   mf3_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;

   logic                 en, pop, b_adv;
   logic [ADDR_W-1:0]    head_addr, b_addr;
   logic [2*PW-1:0]      pair, wr_pair;
   tri_type              col_lo, col_mid, col_hi;

   assign en        = !rsp_valid_ff || rsp_bus.ready;
   assign pop       = en && queue_valid;
   assign queue_pop = pop;
   assign b_adv     = en && b_valid_ff;
   assign head_addr = ADDR_W'(queue_head.col);
   assign b_addr    = ADDR_W'(b_op_ff.col);
   assign fwd_in    = b_valid_ff && queue_valid && (b_addr == head_addr);

   // previous push wrote this column at the same edge as our read
   assign pair    = fwd_ff ? fwd_pair_ff : rdata_ff;
   assign wr_pair = {pair[PW-1:0], b_op_ff.value};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = pair[2*PW-1:PW];
      win_in[1][2] = pair[PW-1:0];
      win_in[2][2] = b_op_ff.value;
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         col_lo[c]  = min2(min2(s1_win_ff[0][c], s1_win_ff[1][c]), s1_win_ff[2][c]);
         col_hi[c]  = max2(max2(s1_win_ff[0][c], s1_win_ff[1][c]), s1_win_ff[2][c]);
         col_mid[c] = med3(s1_win_ff[0][c], s1_win_ff[1][c], s1_win_ff[2][c]);
      end
   end

   always_comb begin
      rsp_data_in.pixel_out  = s3_border_ff ? s3_center_ff :
                               med3(s3_maxlo_ff, s3_medmid_ff, s3_minhi_ff);
      rsp_data_in.frame_last = s3_last_ff;
   end

   always_ff @(posedge clock) begin
      if (pop)
         rdata_ff <= line_mem[head_addr];
      if (b_adv)
         line_mem[b_addr] <= wr_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff   <= queue_valid;
         fwd_ff       <= fwd_in;
         s1_valid_ff  <= b_valid_ff && b_op_ff.emit;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_op_ff      <= queue_head;
         fwd_pair_ff  <= wr_pair;
         if (b_valid_ff)
            win_ff <= win_in;
         s1_win_ff    <= win_in;
         s1_border_ff <= b_op_ff.border;
         s1_last_ff   <= b_op_ff.last;
         s2_lo_ff     <= col_lo;
         s2_mid_ff    <= col_mid;
         s2_hi_ff     <= col_hi;
         s2_center_ff <= s1_win_ff[1][1];
         s2_border_ff <= s1_border_ff;
         s2_last_ff   <= s1_last_ff;
         s3_maxlo_ff  <= max2(max2(s2_lo_ff[0], s2_lo_ff[1]), s2_lo_ff[2]);
         s3_medmid_ff <= med3(s2_mid_ff[0], s2_mid_ff[1], s2_mid_ff[2]);
         s3_minhi_ff  <= min2(min2(s2_hi_ff[0], s2_hi_ff[1]), s2_hi_ff[2]);
         s3_center_ff <= s2_center_ff;
         s3_border_ff <= s2_border_ff;
         s3_last_ff   <= s2_last_ff;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // Forwarding only ever applies to an op sitting in the memory stage.
   a_fwd_needs_op: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> b_valid_ff)
      else $error("forward flag without op in memory stage");

endmodule

`default_nettype wire

// File: rtl/median_filter_3x3.sv
// Top level of the streaming 3x3 median filter.
`default_nettype none

// Streaming 3x3 median filter for 8-bit grayscale frames in raster order.
// Each req beat is a pixel (op = OP_PIXEL) or a drain (op = OP_DRAIN); each
// rsp beat is one filtered pixel, the median of its 3x3 neighborhood inside
// the border and the original value on the first/last row and column.
// Output k appears once input k+W+1 is in, so after the W*H pixels of a
// frame the user sends drain beats to flush the last W+1 outputs; the final
// output carries frame_last and the block is then ready for the next frame.
// Pixels after the frame is complete and drains before it is complete are
// taken and dropped. Width/height CSRs (index CSR_IMAGE_WIDTH/HEIGHT) take
// 0 as 1 and saturate at MAX_WIDTH/MAX_HEIGHT; a write restarts the frame
// and must only be done while the block is idle.
// Rate: one beat per clock while rsp is not stalled, set by the single line
// store memory (one read and one write port, MAX_WIDTH x 16 bits) that each
// beat not dropped passes through once. The one exception is the first drain
// of a single-row frame, pushed twice; no beat is taken until both are queued.
// A result is registered in turn by queue, memory read, window, column sort,
// partial medians and result register. A stalled rsp side stalls the back
// end as a whole; the four-entry queue lets the front end keep taking beats
// meanwhile. The line stores need no clearing after reset.
module median_filter_3x3 #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   mf3_stream_if.sink                         req_bus,
   mf3_stream_if.source                       rsp_bus,
   input  wire logic                          csr_write_en,
   input  wire logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mf3_pkg::CFG_W-1:0]     csr_write_data
);

   // front -> queue
   logic                 queue_push;
   logic                 queue_full;
   mf3_pkg::push_op_type queue_in;

   // queue -> back
   logic                 queue_pop;
   logic                 queue_valid;
   mf3_pkg::push_op_type queue_head;

   // Front end: CSRs, frame position tracking, beat classification.
   mf3_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .queue_full     (queue_full),
      .queue_push     (queue_push),
      .queue_data     (queue_in)
   );

   // Decoupling queue of pushes.
   mf3_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_in),
      .full      (queue_full),
      .pop       (queue_pop),
      .head      (queue_head),
      .not_empty (queue_valid)
   );

   // Back end: line stores, window, median pipeline, result register.
   mf3_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire
